// ===== rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants and types for the page frame allocator: field widths,
// command and status codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int ADDR_W  = 39;
   localparam int CAP_W   = 16;
   localparam int COUNT_W = 8;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int CSR_W   = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

   // commands
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_MEM    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_ADDR  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_OVER_FREE = 2'd3;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_TABLE_BASE    = 2'd0;
   localparam logic [CSR_W-1:0] CSR_REGION_START  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_REGION_STOP   = 2'd2;
   localparam logic [CSR_W-1:0] CSR_PAGE_CAPACITY = 2'd3;

   // register reset values
   localparam logic [ADDR_W-1:0] TABLE_BASE_RST   = 39'h00_8000_0000;
   localparam logic [ADDR_W-1:0] REGION_START_RST = 39'h00_8000_0000;
   localparam logic [ADDR_W-1:0] REGION_STOP_RST  = 39'h00_8800_0000;
   localparam logic [CAP_W-1:0]  CAPACITY_RST     = 16'd0;

   // address check results
   typedef struct packed {
      logic in_table;   // at or above table base and index below page count
      logic free_ok;    // aligned, inside the free region and inside the table
   } addr_chk_type;

endpackage

// ===== rtl/pfa_ram.sv =====
// ----------------------------------------------------------------------------
// pfa_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. No reset on the contents.
// ----------------------------------------------------------------------------
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pfa_addr_check.sv =====
// ----------------------------------------------------------------------------
// pfa_addr_check
// Maps a physical page address to a count table index and checks it against
// the table bounds, the free region and page alignment.
// ----------------------------------------------------------------------------
module pfa_addr_check #(
   parameter int NUM_PAGES       = 32768,
   parameter int PAGE_BYTES_LOG2 = 12
) (
   input  logic [pfa_pkg::ADDR_W-1:0]    addr,
   input  logic [pfa_pkg::ADDR_W-1:0]    table_base,
   input  logic [pfa_pkg::ADDR_W-1:0]    region_start,
   input  logic [pfa_pkg::ADDR_W-1:0]    region_stop,
   output pfa_pkg::addr_chk_type         chk,
   output logic [$clog2(NUM_PAGES)-1:0]  idx
);
   import pfa_pkg::*;

   localparam int IDX_W = $clog2(NUM_PAGES);
   localparam int PN_W  = ADDR_W - PAGE_BYTES_LOG2;

   logic [ADDR_W-1:0] offset;
   logic [PN_W-1:0]   page_num;
   logic              above_base;
   logic              below_top;
   logic              aligned;
   logic              in_region;

   always_comb begin
      offset     = addr - table_base;
      page_num   = offset[ADDR_W-1:PAGE_BYTES_LOG2];
      above_base = addr >= table_base;
      below_top  = 64'(page_num) < 64'(NUM_PAGES);
      aligned    = addr[PAGE_BYTES_LOG2-1:0] == '0;
      in_region  = (addr >= region_start) && (addr < region_stop);
      chk.in_table = above_base && below_top;
      chk.free_ok  = aligned && in_region && above_base && below_top;
      idx          = IDX_W'(page_num);
   end

endmodule

// ===== rtl/page_frame_allocator_refcount.sv =====
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount
// Physical page allocator: LIFO free stack of page indices plus an 8-bit
// reference count per page, both held in synchronous RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command word (allocate, free, add reference, query)
//   with a page address; rsp_* returns one word per command: status, the
//   allocated address, the page's count after the command and the number
//   of free pages. csr_* writes the table base, free region bounds and page
//   capacity; write them only while no command is in flight.
//   One command is in flight at a time. A free, add or query command
//   passes DECODE (count read) and then FINISH (update and response
//   load); allocate passes DECODE (stack read), STACK (count read) and
//   FINISH. Out-of-memory and rejected commands go from DECODE
//   straight to FINISH. req_ready is high only in IDLE, so the next
//   command is taken only once the response has loaded.
//   After reset the count RAM is cleared one entry per cycle, all
//   NUM_PAGES entries, with req_ready low. The stack starts empty.
//   A response waits in the output register while rsp_ready is low; the
//   next command may be accepted meanwhile and stalls at its update step.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount #(
   parameter int NUM_PAGES       = 32768,
   parameter int PAGE_BYTES_LOG2 = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [pfa_pkg::CMD_W-1:0]   req_command,
   input  logic [pfa_pkg::ADDR_W-1:0]  req_page_address,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pfa_pkg::STAT_W-1:0]  rsp_status,
   output logic [pfa_pkg::ADDR_W-1:0]  rsp_result_address,
   output logic [pfa_pkg::COUNT_W-1:0] rsp_ref_count,
   output logic [pfa_pkg::CAP_W-1:0]   rsp_pages_avail,
   input  logic                        csr_wen,
   input  logic [pfa_pkg::CSR_W-1:0]   csr_addr,
   input  logic [pfa_pkg::ADDR_W-1:0]  csr_wdata
);
   import pfa_pkg::*;

   localparam int IDX_W   = $clog2(NUM_PAGES);
   localparam int DEPTH_W = $clog2(NUM_PAGES + 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DECODE = 3'd2;
   localparam logic [2:0] ST_STACK  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // configuration
   logic [ADDR_W-1:0] table_base_ff;
   logic [ADDR_W-1:0] region_start_ff;
   logic [ADDR_W-1:0] region_stop_ff;
   logic [CAP_W-1:0]  capacity_ff;

   // control
   logic [2:0]         state_ff, state_in;
   logic [IDX_W-1:0]   clr_ptr_ff, clr_ptr_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [STAT_W-1:0]  stat_ff, stat_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [CAP_W-1:0]    rsp_free_ff;
   logic                rsp_load;
   logic [STAT_W-1:0]   rsp_status_in;
   logic [ADDR_W-1:0]   rsp_addr_in;
   logic [COUNT_W-1:0]  rsp_count_in;
   logic [CAP_W-1:0]    rsp_free_in;

   // memory ports
   logic               cnt_wr_en, cnt_rd_en;
   logic [IDX_W-1:0]   cnt_wr_addr, cnt_rd_addr;
   logic [COUNT_W-1:0] cnt_wr_data, cnt_q;
   logic               stk_wr_en, stk_rd_en;
   logic [IDX_W-1:0]   stk_wr_addr, stk_rd_addr;
   logic [IDX_W-1:0]   stk_q;

   // address check
   addr_chk_type       chk;
   logic [IDX_W-1:0]   chk_idx;

   logic               accept;
   logic               commit;
   logic [DEPTH_W-1:0] depth_m1;
   logic [COUNT_W-1:0] new_count;
   logic [31:0]        depth_ext;
   logic               over_free;

   pfa_addr_check #(
      .NUM_PAGES       (NUM_PAGES),
      .PAGE_BYTES_LOG2 (PAGE_BYTES_LOG2)
   ) u_check (
      .addr         (addr_ff),
      .table_base   (table_base_ff),
      .region_start (region_start_ff),
      .region_stop  (region_stop_ff),
      .chk          (chk),
      .idx          (chk_idx)
   );

   pfa_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (NUM_PAGES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_q)
   );

   pfa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NUM_PAGES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (idx_ff),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_q)
   );

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign depth_m1  = depth_ff - 1'b1;
   assign over_free = (capacity_ff != '0) && (32'(depth_ff) >= 32'(capacity_ff));

   always_comb begin
      state_in    = state_ff;
      clr_ptr_in  = clr_ptr_ff;
      depth_in    = depth_ff;
      idx_in      = idx_ff;
      stat_in     = stat_ff;
      cnt_wr_en   = 1'b0;
      cnt_wr_addr = idx_ff;
      cnt_wr_data = '0;
      cnt_rd_en   = 1'b0;
      cnt_rd_addr = chk_idx;
      stk_wr_en   = 1'b0;
      stk_wr_addr = depth_ff[IDX_W-1:0];
      stk_rd_en   = 1'b0;
      stk_rd_addr = depth_m1[IDX_W-1:0];
      new_count   = cnt_q;
      rsp_load      = 1'b0;
      rsp_status_in = stat_ff;
      rsp_addr_in   = '0;
      rsp_count_in  = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_ptr_ff;
            clr_ptr_in  = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == IDX_W'(NUM_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            idx_in   = chk_idx;
            stat_in  = STAT_OK;
            state_in = ST_FINISH;
            unique case (cmd_ff)
               CMD_ALLOC: begin
                  if (depth_ff == '0) begin
                     stat_in = STAT_NO_MEM;
                  end else begin
                     // pop: fetch the top entry, then its count
                     stk_rd_en = 1'b1;
                     depth_in  = depth_m1;
                     state_in  = ST_STACK;
                  end
               end
               CMD_FREE: begin
                  priority if (over_free) begin
                     stat_in = STAT_OVER_FREE;
                  end else if (!chk.free_ok) begin
                     stat_in = STAT_BAD_ADDR;
                  end else begin
                     cnt_rd_en = 1'b1;
                  end
               end
               default: begin
                  if (!chk.in_table) begin
                     stat_in = STAT_BAD_ADDR;
                  end else begin
                     cnt_rd_en = 1'b1;
                  end
               end
            endcase
         end
         ST_STACK: begin
            idx_in      = stk_q;
            cnt_rd_en   = 1'b1;
            cnt_rd_addr = stk_q;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            unique case (cmd_ff)
               CMD_ALLOC, CMD_ADD: begin
                  new_count = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
               end
               CMD_FREE: begin
                  new_count = (cnt_q == '0) ? cnt_q : cnt_q - 1'b1;
               end
               default: begin
                  new_count = cnt_q;
               end
            endcase
            if (commit) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (stat_ff == STAT_OK) begin
                  rsp_count_in = new_count;
                  cnt_wr_en    = cmd_ff != CMD_QUERY;
                  cnt_wr_data  = new_count;
                  if (cmd_ff == CMD_ALLOC) begin
                     rsp_addr_in = table_base_ff
                                 + (ADDR_W'(idx_ff) << PAGE_BYTES_LOG2);
                  end
                  // push the page whenever a free leaves its count at zero, unless the stack is full
                  if (cmd_ff == CMD_FREE && new_count == '0
                      && 32'(depth_ff) < 32'(NUM_PAGES)) begin
                     stk_wr_en = 1'b1;
                     depth_in  = depth_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign depth_ext    = 32'(depth_in);
   assign rsp_free_in  = depth_ext[CAP_W-1:0];
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ptr_ff      <= '0;
         depth_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         table_base_ff   <= TABLE_BASE_RST;
         region_start_ff <= REGION_START_RST;
         region_stop_ff  <= REGION_STOP_RST;
         capacity_ff     <= CAPACITY_RST;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            unique case (csr_addr)
               CSR_TABLE_BASE:    table_base_ff   <= csr_wdata;
               CSR_REGION_START:  region_start_ff <= csr_wdata;
               CSR_REGION_STOP:   region_stop_ff  <= csr_wdata;
               CSR_PAGE_CAPACITY: capacity_ff     <= csr_wdata[CAP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         addr_ff <= req_page_address;
      end
      idx_ff  <= idx_in;
      stat_ff <= stat_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_free_ff   <= rsp_free_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_ref_count      = rsp_count_ff;
   assign rsp_pages_avail    = rsp_free_ff;

endmodule

// ===== bench/tb_page_frame_allocator_refcount.sv =====
// ----------------------------------------------------------------------------
// tb_page_frame_allocator_refcount
// Self-checking bench for the page frame allocator. A shadow allocator (free
// stack, reference counts, register copies) runs in step with every accepted
// command word, and each response word is compared field by field in order.
// Directed runs cover the empty stack, address rejects, count saturation,
// over-free and register extremes; random traffic then works a small pool
// of pages under three register settings.
// ----------------------------------------------------------------------------
module tb_page_frame_allocator_refcount;

   timeunit 1ns;
   timeprecision 1ps;

   import pfa_pkg::*;

   localparam int NUM_FRAMES  = 32768;
   localparam int PAGE_LOG2   = 12;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_WAIT  = 8;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [ADDR_W-1:0]  address;
      logic [COUNT_W-1:0] count;
      logic [CAP_W-1:0]   pages_avail;
   } page_outcome_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command      = CMD_ALLOC;
   logic [ADDR_W-1:0]   req_page_address = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [ADDR_W-1:0]   rsp_result_address;
   logic [COUNT_W-1:0]  rsp_ref_count;
   logic [CAP_W-1:0]    rsp_pages_avail;
   logic                csr_wen          = 1'b0;
   logic [CSR_W-1:0]    csr_addr         = CSR_TABLE_BASE;
   logic [ADDR_W-1:0]   csr_wdata        = '0;

   // shadow allocator state
   logic [14:0]         frame_stack [NUM_FRAMES];
   logic [COUNT_W-1:0]  frame_refs  [NUM_FRAMES];
   int unsigned         stack_top    = 0;
   logic [ADDR_W-1:0]   cfg_table_base   = TABLE_BASE_RST;
   logic [ADDR_W-1:0]   cfg_region_start = REGION_START_RST;
   logic [ADDR_W-1:0]   cfg_region_stop  = REGION_STOP_RST;
   logic [CAP_W-1:0]    cfg_capacity     = CAPACITY_RST;

   page_outcome_type    page_outcomes [$];
   int                  error_count = 0;
   int unsigned         cycle_count = 0;
   int unsigned         gap_pct     = 36;
   int unsigned         stall_pct   = 36;

   logic [CMD_W-1:0]    addressed_cmds [3] = '{CMD_FREE, CMD_ADD, CMD_QUERY};

   page_frame_allocator_refcount #(
      .NUM_PAGES       (NUM_FRAMES),
      .PAGE_BYTES_LOG2 (PAGE_LOG2)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_page_address   (req_page_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_result_address (rsp_result_address),
      .rsp_ref_count      (rsp_ref_count),
      .rsp_pages_avail    (rsp_pages_avail),
      .csr_wen            (csr_wen),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: no progress, run stopped", $time);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Apply one command to the shadow allocator and return the response it gives.
   function automatic page_outcome_type apply_page_command(input logic [CMD_W-1:0]  cmd,
                                                           input logic [ADDR_W-1:0] addr);
      page_outcome_type  res;
      logic [ADDR_W-1:0] offset;
      logic [14:0]       slot;
      logic              in_table;
      res      = '0;
      offset   = addr - cfg_table_base;
      in_table = (addr >= cfg_table_base) && ((offset >> PAGE_LOG2) < NUM_FRAMES);
      slot     = offset[PAGE_LOG2 +: 15];
      case (cmd)
         CMD_ALLOC: begin
            if (stack_top == 0) begin
               res.status = STAT_NO_MEM;
            end else begin
               stack_top--;
               slot = frame_stack[stack_top];
               if (frame_refs[slot] != COUNT_MAX) frame_refs[slot]++;
               res.count   = frame_refs[slot];
               res.address = cfg_table_base + (ADDR_W'(slot) << PAGE_LOG2);
            end
         end
         CMD_FREE: begin
            // over-free wins over every address check
            if (cfg_capacity != 0 && stack_top >= cfg_capacity) begin
               res.status = STAT_OVER_FREE;
            end else if (addr[PAGE_LOG2-1:0] != 0 || addr < cfg_region_start ||
                         addr >= cfg_region_stop || !in_table) begin
               res.status = STAT_BAD_ADDR;
            end else begin
               if (frame_refs[slot] != 0) frame_refs[slot]--;
               // a full stack drops the push silently
               if (frame_refs[slot] == 0 && stack_top < NUM_FRAMES) begin
                  frame_stack[stack_top] = slot;
                  stack_top++;
               end
               res.count = frame_refs[slot];
            end
         end
         default: begin
            if (!in_table) begin
               res.status = STAT_BAD_ADDR;
            end else begin
               if (cmd == CMD_ADD && frame_refs[slot] != COUNT_MAX) frame_refs[slot]++;
               res.count = frame_refs[slot];
            end
         end
      endcase
      res.pages_avail = CAP_W'(stack_top);
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [ADDR_W-1:0] want,
                                input logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      page_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (page_outcomes.size() == 0) begin
            $display("%0t ns: unrequested response, status %0d address 0x%0h count %0d free %0d",
                     $time, rsp_status, rsp_result_address, rsp_ref_count, rsp_pages_avail);
            error_count++;
         end else begin
            want = page_outcomes.pop_front();
            compare_field("status", ADDR_W'(want.status), ADDR_W'(rsp_status));
            compare_field("result_address", want.address, rsp_result_address);
            compare_field("ref_count", ADDR_W'(want.count), ADDR_W'(rsp_ref_count));
            compare_field("pages_avail", ADDR_W'(want.pages_avail), ADDR_W'(rsp_pages_avail));
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Send one command word; valid stays up after acceptance unless a gap follows.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_page_address <= addr;
      do @(posedge clock); while (!req_ready);
      page_outcomes.push_back(apply_page_command(cmd, addr));
   endtask

   // Drop valid and hold until every response is back and the pipe is quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (page_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_W-1:0] idx, input logic [ADDR_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      case (idx)
         CSR_TABLE_BASE:    cfg_table_base   = value;
         CSR_REGION_START:  cfg_region_start = value;
         CSR_REGION_STOP:   cfg_region_stop  = value;
         CSR_PAGE_CAPACITY: cfg_capacity     = value[CAP_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic restore_defaults();
      write_csr(CSR_TABLE_BASE, TABLE_BASE_RST);
      write_csr(CSR_REGION_START, REGION_START_RST);
      write_csr(CSR_REGION_STOP, REGION_STOP_RST);
      write_csr(CSR_PAGE_CAPACITY, ADDR_W'(CAPACITY_RST));
   endtask

   task automatic test_directed_basics();
      send_word(CMD_ALLOC, '0);                 // empty stack
      send_word(CMD_FREE,  39'h00_8000_0000);   // first page
      send_word(CMD_FREE,  39'h00_87FF_F000);   // last page
      send_word(CMD_FREE,  39'h00_8000_0800);   // misaligned
      send_word(CMD_FREE,  39'h00_7FFF_F000);   // below region
      send_word(CMD_FREE,  39'h00_8800_0000);   // at region stop
      send_word(CMD_ADD,   39'h00_8000_0FFF);   // offset bits dropped
      send_word(CMD_QUERY, 39'h00_8000_0000);
      send_word(CMD_QUERY, 39'h00_7FFF_FFFF);   // below table
      send_word(CMD_ADD,   39'h00_8800_0000);   // index past table
      send_word(CMD_QUERY, 39'h7F_FFFF_FFFF);
      send_word(CMD_QUERY, 39'h00_0000_0000);
      send_word(CMD_ALLOC, 39'h7F_FFFF_FFFF);
      send_word(CMD_ALLOC, '0);
      send_word(CMD_ALLOC, '0);                 // empty again
      send_word(CMD_FREE,  39'h00_8000_0000);
      send_word(CMD_FREE,  39'h00_8000_0000);   // reaches zero, push
      send_word(CMD_FREE,  39'h00_8000_0000);   // zero count, push again
      send_word(CMD_ADD,   39'h00_87FF_FFFF);
      send_word(CMD_QUERY, 39'h00_87FF_F001);
      settle();
   endtask

   task automatic test_count_saturation();
      logic [ADDR_W-1:0] page;
      page = TABLE_BASE_RST + 39'h12_3000;
      send_word(CMD_FREE, page);
      repeat (COUNT_MAX + 1) send_word(CMD_ADD, page);
      send_word(CMD_QUERY, page);
      // pop the saturated page straight off the top of the stack
      send_word(CMD_ALLOC, '0);
      send_word(CMD_FREE, page);
      settle();
   endtask

   task automatic test_over_free();
      send_word(CMD_FREE, TABLE_BASE_RST);
      settle();
      write_csr(CSR_PAGE_CAPACITY, ADDR_W'(stack_top));
      send_word(CMD_FREE, TABLE_BASE_RST);
      send_word(CMD_FREE, TABLE_BASE_RST + 39'h1);   // rejected before alignment
      send_word(CMD_ALLOC, '0);
      send_word(CMD_FREE, TABLE_BASE_RST);
      send_word(CMD_FREE, TABLE_BASE_RST);
      settle();
      write_csr(CSR_PAGE_CAPACITY, '0);
   endtask

   task automatic test_config_extremes();
      write_csr(CSR_TABLE_BASE, '0);
      write_csr(CSR_REGION_START, '0);
      write_csr(CSR_REGION_STOP, '1);
      send_word(CMD_FREE,  39'h00_0000_0000);
      send_word(CMD_FREE,  39'h00_07FF_F000);
      send_word(CMD_FREE,  39'h00_0800_0000);   // inside region, past table
      send_word(CMD_QUERY, 39'h7F_FFFF_FFFF);
      send_word(CMD_ALLOC, '0);
      settle();
      write_csr(CSR_TABLE_BASE, '1);
      send_word(CMD_ALLOC, '0);                 // address wraps
      send_word(CMD_QUERY, 39'h7F_FFFF_FFFF);
      send_word(CMD_ADD,   39'h00_0000_0000);
      send_word(CMD_FREE,  39'h7F_FFFF_FFFF);
      settle();
      write_csr(CSR_REGION_START, '1);
      send_word(CMD_FREE,  39'h7F_FFFF_F000);
      send_word(CMD_FREE,  39'h00_0000_0000);
      settle();
      restore_defaults();
   endtask

   // Mostly well-formed traffic on a small page pool, with some noise mixed in.
   task automatic run_traffic_phase(input int unsigned items);
      logic [ADDR_W-1:0] pool [16];
      logic [ADDR_W-1:0] addr;
      logic [CMD_W-1:0]  cmd;
      int unsigned       pick;
      int unsigned       slot;
      foreach (pool[k]) begin
         if (k < 4) slot = $urandom_range(24);
         else if (k < 6) slot = $urandom_range(NUM_FRAMES - 1, NUM_FRAMES - 24);
         else slot = $urandom_range(NUM_FRAMES - 1);
         pool[k] = cfg_table_base + (ADDR_W'(slot) << PAGE_LOG2);
      end
      repeat (items) begin
         pick = $urandom_range(99);
         addr = pool[$urandom_range(15)];
         if (pick < 24) begin
            cmd  = CMD_ALLOC;
            addr = ADDR_W'({$urandom, $urandom});
         end else if (pick < 54) begin
            cmd = CMD_FREE;
         end else if (pick < 80) begin
            cmd = (pick < 67) ? CMD_ADD : CMD_QUERY;
            if ($urandom_range(3) == 0) addr[PAGE_LOG2-1:0] = PAGE_LOG2'($urandom);
         end else begin
            cmd = addressed_cmds[$urandom_range(2)];
            if (pick < 90) addr = addr ^ (ADDR_W'(1) << $urandom_range(ADDR_W - 1));
            else addr = ADDR_W'({$urandom, $urandom});
         end
         send_word(cmd, addr);
      end
      settle();
   endtask

   task automatic test_random_traffic();
      logic [ADDR_W-1:0] base;
      run_traffic_phase(140);

      // shifted table, region trimmed at both ends, small capacity
      base = {12'($urandom_range(4094)), 15'($urandom), 12'h000};
      write_csr(CSR_TABLE_BASE, base);
      write_csr(CSR_REGION_START, base + (ADDR_W'(16) << PAGE_LOG2));
      write_csr(CSR_REGION_STOP, base + (ADDR_W'(NUM_FRAMES - 16) << PAGE_LOG2));
      write_csr(CSR_PAGE_CAPACITY, ADDR_W'(40));
      run_traffic_phase(140);

      // back-to-back stretch, capacity equal to the page count
      restore_defaults();
      write_csr(CSR_PAGE_CAPACITY, ADDR_W'(NUM_FRAMES));
      gap_pct   = 0;
      stall_pct = 0;
      run_traffic_phase(120);
      gap_pct   = 36;
      stall_pct = 36;
      write_csr(CSR_PAGE_CAPACITY, '0);
   endtask

   initial begin
      foreach (frame_refs[i]) frame_refs[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_count_saturation();
      test_over_free();
      test_config_extremes();
      test_random_traffic();
      settle();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== page_frame_allocator_refcount.f =====
rtl/pfa_pkg.sv
rtl/pfa_ram.sv
rtl/pfa_addr_check.sv
rtl/page_frame_allocator_refcount.sv
bench/tb_page_frame_allocator_refcount.sv
